FILE: rtl/core/spq_pkg.sv
// ============================================================================
// spq_pkg
// Shared widths, codes and control types for the sorted priority queue.
// ============================================================================
`default_nettype none

package spq_pkg;

    // Field widths.
    localparam int KEY_W     = 32;
    localparam int PAY_W     = 32;
    localparam int COUNT_W   = 5;
    localparam int STATUS_W  = 2;

    // Default number of entry cells.
    localparam int DEFAULT_CAPACITY = 16;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast control that every cell sees in the same cycle.
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [KEY_W-1:0] key;
        logic        [PAY_W-1:0] payload;
    } ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/spq_cell.sv
// ============================================================================
// spq_cell
// One entry cell of the shift-register queue: holds a key and a payload and
// exchanges them with its neighbors on insert and remove.
// ============================================================================
`default_nettype none

module spq_cell (
    input  wire logic                            clk,
    input  wire spq_pkg::ctl_t                   ctl,
    input  wire logic                            occupied,
    input  wire logic                            prev_keep,
    input  wire logic signed [spq_pkg::KEY_W-1:0] prev_key,
    input  wire logic        [spq_pkg::PAY_W-1:0] prev_payload,
    input  wire logic signed [spq_pkg::KEY_W-1:0] next_key,
    input  wire logic        [spq_pkg::PAY_W-1:0] next_payload,
    output logic                                 keep,
    output logic signed [spq_pkg::KEY_W-1:0]     key_q,
    output logic        [spq_pkg::PAY_W-1:0]     payload_q
);

    logic signed [spq_pkg::KEY_W-1:0] key_reg;
    logic signed [spq_pkg::KEY_W-1:0] key_next;
    logic        [spq_pkg::PAY_W-1:0] payload_reg;
    logic        [spq_pkg::PAY_W-1:0] payload_next;

    // The cell keeps its entry on insert when it holds a key not above the new one.
    assign keep = occupied && (key_reg <= ctl.key);

    // Next entry: hold, take the new item, take the left neighbor or the right one.
    // Insert and remove never occur together.
    always_comb
    begin
        key_next     = key_reg;
        payload_next = payload_reg;
        if (ctl.ins)
        begin
            if (!keep)
            begin
                if (prev_keep)
                begin
                    key_next     = ctl.key;
                    payload_next = ctl.payload;
                end
                else
                begin
                    key_next     = prev_key;
                    payload_next = prev_payload;
                end
            end
        end
        else if (ctl.rem)
        begin
            key_next     = next_key;
            payload_next = next_payload;
        end
    end

    // Entry storage has no reset; occupancy comes from the count.
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
    end

    assign key_q     = key_reg;
    assign payload_q = payload_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_unit.sv
// ============================================================================
// sorted_priority_queue_unit
// Priority queue kept sorted by ascending signed key in a chain of cells.
// ============================================================================
// The result of an accepted item is registered and appears on the outputs in
// the next cycle. Throughput: one item per cycle while the result register is
// free or being drained; every cell compares against the new key in parallel
// and shifts by one position.
// Reset clears the entry count and the output valid; entry storage is not reset.
`default_nettype none

module sorted_priority_queue_unit #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             cmd,
    input  wire logic signed [spq_pkg::KEY_W-1:0]  key,
    input  wire logic        [spq_pkg::PAY_W-1:0]  payload,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic        [spq_pkg::STATUS_W-1:0]   status,
    output logic signed [spq_pkg::KEY_W-1:0]      out_key,
    output logic        [spq_pkg::PAY_W-1:0]      out_payload,
    output logic        [spq_pkg::COUNT_W-1:0]    count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                    accept;
    logic                    full;
    logic                    empty;
    spq_pkg::ctl_t           ctl;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    spq_pkg::status_t        status_reg;
    spq_pkg::status_t        status_next;
    logic signed [spq_pkg::KEY_W-1:0] out_key_reg;
    logic signed [spq_pkg::KEY_W-1:0] out_key_next;
    logic [spq_pkg::PAY_W-1:0]        out_payload_reg;
    logic [spq_pkg::PAY_W-1:0]        out_payload_next;
    logic [spq_pkg::COUNT_W-1:0]      count_out_reg;
    logic [spq_pkg::COUNT_W-1:0]      count_out_next;

    logic signed [spq_pkg::KEY_W-1:0] cell_key     [CAPACITY];
    logic        [spq_pkg::PAY_W-1:0] cell_payload [CAPACITY];
    logic                             cell_keep    [CAPACITY];
    logic                             cell_occ     [CAPACITY];

    // Input is taken whenever the result register is free or being drained.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg == CAP_CNT);
    assign empty    = (count_reg == '0);

    // Broadcast control to the cell chain.
    always_comb
    begin
        ctl.ins     = accept && (cmd == spq_pkg::CMD_INSERT) && !full;
        ctl.rem     = accept && (cmd == spq_pkg::CMD_REMOVE) && !empty;
        ctl.key     = key;
        ctl.payload = payload;
    end

    // Cell chain; cell i is occupied while i is below the count.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                             p_keep;
        logic signed [spq_pkg::KEY_W-1:0] p_key;
        logic        [spq_pkg::PAY_W-1:0] p_payload;
        logic signed [spq_pkg::KEY_W-1:0] n_key;
        logic        [spq_pkg::PAY_W-1:0] n_payload;

        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign p_keep    = 1'b1;
            assign p_key     = '0;
            assign p_payload = '0;
        end
        else
        begin : g_body
            assign p_keep    = cell_keep[i-1];
            assign p_key     = cell_key[i-1];
            assign p_payload = cell_payload[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign n_key     = '0;
            assign n_payload = '0;
        end
        else
        begin : g_inner
            assign n_key     = cell_key[i+1];
            assign n_payload = cell_payload[i+1];
        end

        spq_cell u_cell (
            .clk          (clk),
            .ctl          (ctl),
            .occupied     (cell_occ[i]),
            .prev_keep    (p_keep),
            .prev_key     (p_key),
            .prev_payload (p_payload),
            .next_key     (n_key),
            .next_payload (n_payload),
            .keep         (cell_keep[i]),
            .key_q        (cell_key[i]),
            .payload_q    (cell_payload[i])
        );
    end

    // Count update and result formation.
    always_comb
    begin
        count_next       = count_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        out_key_next     = out_key_reg;
        out_payload_next = out_payload_reg;
        count_out_next   = count_out_reg;

        if (ctl.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        if (accept)
        begin
            out_valid_next   = 1'b1;
            out_key_next     = '0;
            out_payload_next = '0;
            count_out_next   = spq_pkg::COUNT_W'(count_next);
            priority if (cmd == spq_pkg::CMD_INSERT)
            begin
                status_next = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
            end
            else if (empty)
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
            else
            begin
                status_next      = spq_pkg::ST_OK;
                out_key_next     = cell_key[0];
                out_payload_next = cell_payload[0];
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        out_key_reg     <= out_key_next;
        out_payload_reg <= out_payload_next;
        count_out_reg   <= count_out_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_payload_reg;
    assign count       = count_out_reg;

    // The count never exceeds the number of cells.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    // A successful insert grows the count by exactly one.
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not advance the count");

    // The two front cells stay in ascending key order.
    a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_key[0] <= cell_key[1]))
        else $error("front cells out of order");

    // An empty result carries zero key and zero count.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == spq_pkg::ST_EMPTY)
            |-> (out_key_reg == '0 && count_out_reg == '0))
        else $error("empty result with nonzero fields");

endmodule

`default_nettype wire
